FILE: rtl/ssd_pkg.sv
package ssd_pkg;

  // Table geometry and counter width.
  localparam int TableEntries = 32;
  localparam int CountBits    = 16;
  localparam int IdxW         = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int UsedW        = $clog2(TableEntries + 1);

  // Field widths fixed by the interface.
  localparam int RatioW    = 4;
  localparam int OutCountW = 16;
  localparam int IpW       = 32;

  // Product of the ratio and a counter.
  localparam int ProdW = CountBits + RatioW;

  localparam logic [RatioW-1:0]    RatioReset = RatioW'(3);
  localparam logic [15:0]          EthIpv4    = 16'h0800;
  localparam logic [7:0]           ProtoTcp   = 8'd6;
  localparam logic [CountBits-1:0] CountMax   = {CountBits{1'b1}};

  // Input item kinds.
  localparam logic KindPacket = 1'b0;
  localparam logic KindReport = 1'b1;

  typedef enum logic [1:0] {
    StIgnored = 2'd0,
    StCounted = 2'd1,
    StNew     = 2'd2,
    StFull    = 2'd3
  } pkt_status_e;

  // One stored host entry.
  typedef struct packed {
    logic [IpW-1:0]       host;
    logic [CountBits-1:0] syn;
    logic [CountBits-1:0] synack;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  // One result beat.
  typedef struct packed {
    pkt_status_e          packet_status;
    logic                 suspect_valid;
    logic [IpW-1:0]       suspect_ip;
    logic [OutCountW-1:0] syn_total;
    logic [OutCountW-1:0] synack_total;
    logic                 last;
  } out_beat_t;

  // Engine status seen by the top level.
  typedef struct packed {
    logic             idle;
    logic [UsedW-1:0] used;
  } eng_stat_t;

  // Saturating increment of a counter.
  function automatic logic [CountBits-1:0] sat_inc(logic [CountBits-1:0] v);
    logic [CountBits-1:0] r;
    r = (v == CountMax) ? v : v + 1'b1;
    return r;
  endfunction

  // Clamp a counter to the width of the result fields.
  function automatic logic [OutCountW-1:0] sat_total(logic [CountBits-1:0] v);
    logic [CountBits+OutCountW-1:0] w;
    logic [OutCountW-1:0]           r;
    w = (CountBits + OutCountW)'(v);
    if (w > (CountBits + OutCountW)'({OutCountW{1'b1}})) begin
      r = {OutCountW{1'b1}};
    end else begin
      r = w[OutCountW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/ssd_if.sv
// Input channel: parsed packet headers and report requests.
interface ssd_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] eth_type;
  logic [7:0]  ip_protocol;
  logic [31:0] source_ip;
  logic [31:0] dest_ip;
  logic        syn_flag;
  logic        ack_flag;

  modport source (
    output valid, kind, eth_type, ip_protocol, source_ip, dest_ip, syn_flag, ack_flag,
    input  ready
  );

  modport sink (
    input  valid, kind, eth_type, ip_protocol, source_ip, dest_ip, syn_flag, ack_flag,
    output ready
  );
endinterface

// Output channel: packet status and suspect reports.
interface ssd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  packet_status;
  logic        suspect_valid;
  logic [31:0] suspect_ip;
  logic [15:0] syn_total;
  logic [15:0] synack_total;
  logic        last;

  modport source (
    output valid, packet_status, suspect_valid, suspect_ip, syn_total, synack_total, last,
    input  ready
  );

  modport sink (
    input  valid, packet_status, suspect_valid, suspect_ip, syn_total, synack_total, last,
    output ready
  );
endinterface

FILE: rtl/ssd_ram.sv
module ssd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ssd_engine.sv
module ssd_engine import ssd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [RatioW-1:0] scan_ratio_i,
  ssd_in_if.sink            in_i,
  ssd_out_if.source         out_o,
  output logic              ram_we_o,
  output logic [IdxW-1:0]   ram_waddr_o,
  output entry_t            ram_wdata_o,
  output logic              ram_re_o,
  output logic [IdxW-1:0]   ram_raddr_o,
  input  entry_t            ram_rdata_i,
  output eng_stat_t         stat_o
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SEARCH  = 6'b000010,
    S_PUSH    = 6'b000100,
    S_REP_RD  = 6'b001000,
    S_REP_CHK = 6'b010000,
    S_REP_END = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [UsedW-1:0]     used_q, used_d;
  logic [UsedW-1:0]     issue_q, issue_d;
  logic                 rd_valid_q, rd_valid_d;
  logic [IdxW-1:0]      rd_idx_q, rd_idx_d;
  logic [IpW-1:0]       host_q, host_d;
  logic                 is_syn_q, is_syn_d;
  pkt_status_e          status_q, status_d;
  logic [UsedW-1:0]     walk_q, walk_d;
  logic                 pend_valid_q, pend_valid_d;
  entry_t               pend_q, pend_d;
  logic                 out_valid_q, out_valid_d;
  out_beat_t            out_q, out_d;

  logic                 in_fire;
  logic                 slot_free;
  logic                 counted;
  logic                 table_full;
  logic                 hit;
  logic                 miss;
  logic [UsedW-1:0]     walk_m1;
  logic [ProdW-1:0]     ratio_prod;
  logic                 suspect;
  entry_t               new_entry;
  entry_t               inc_entry;

  assign in_fire    = in_i.valid && in_i.ready;
  assign slot_free  = !out_valid_q || out_o.ready;
  assign table_full = (used_q == UsedW'(TableEntries));
  assign walk_m1    = walk_q - 1'b1;

  // A packet counts when it is an IPv4 TCP segment with SYN set.
  assign counted = (in_i.eth_type == EthIpv4) && (in_i.ip_protocol == ProtoTcp) &&
                   in_i.syn_flag;

  // Search outcome: a returned entry matches, or every entry has been compared.
  assign hit  = rd_valid_q && (ram_rdata_i.host == host_q);
  assign miss = !rd_valid_q && (issue_q == used_q);

  // Suspect test on the entry read during the report walk.
  assign ratio_prod = ProdW'(scan_ratio_i) * ProdW'(ram_rdata_i.synack);
  assign suspect    = ProdW'(ram_rdata_i.syn) > ratio_prod;

  // Fresh entry and updated entry for the write-back.
  always_comb begin
    new_entry.host   = host_q;
    new_entry.syn    = is_syn_q ? CountBits'(1) : '0;
    new_entry.synack = is_syn_q ? '0 : CountBits'(1);
    inc_entry        = ram_rdata_i;
    if (is_syn_q) begin
      inc_entry.syn = sat_inc(ram_rdata_i.syn);
    end else begin
      inc_entry.synack = sat_inc(ram_rdata_i.synack);
    end
  end

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    used_d       = used_q;
    issue_d      = issue_q;
    rd_valid_d   = 1'b0;
    rd_idx_d     = rd_idx_q;
    host_d       = host_q;
    is_syn_d     = is_syn_q;
    status_d     = status_q;
    walk_d       = walk_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    ram_we_o     = 1'b0;
    ram_waddr_o  = rd_idx_q;
    ram_wdata_o  = inc_entry;
    ram_re_o     = 1'b0;
    ram_raddr_o  = issue_q[IdxW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.kind == KindReport) begin
            walk_d       = used_q;
            pend_valid_d = 1'b0;
            state_d      = S_REP_RD;
          end else if (!counted) begin
            status_d = StIgnored;
            state_d  = S_PUSH;
          end else begin
            is_syn_d = !in_i.ack_flag;
            host_d   = in_i.ack_flag ? in_i.dest_ip : in_i.source_ip;
            issue_d  = '0;
            state_d  = S_SEARCH;
          end
        end
      end

      S_SEARCH: begin
        if (hit) begin
          ram_we_o = 1'b1;
          status_d = StCounted;
          state_d  = S_PUSH;
        end else if (miss) begin
          if (table_full) begin
            status_d = StFull;
          end else begin
            ram_we_o    = 1'b1;
            ram_waddr_o = used_q[IdxW-1:0];
            ram_wdata_o = new_entry;
            used_d      = used_q + 1'b1;
            status_d    = StNew;
          end
          state_d = S_PUSH;
        end else if (issue_q < used_q) begin
          // Issue the next entry; its data returns in the following cycle.
          ram_re_o   = 1'b1;
          rd_valid_d = 1'b1;
          rd_idx_d   = issue_q[IdxW-1:0];
          issue_d    = issue_q + 1'b1;
        end
      end

      S_PUSH: begin
        if (slot_free) begin
          out_d               = '0;
          out_d.packet_status = status_q;
          out_d.last          = 1'b1;
          out_valid_d         = 1'b1;
          state_d             = S_IDLE;
        end
      end

      S_REP_RD: begin
        // Walk from the newest entry down to the oldest.
        if (walk_q == '0) begin
          state_d = S_REP_END;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = walk_m1[IdxW-1:0];
          walk_d      = walk_m1;
          state_d     = S_REP_CHK;
        end
      end

      S_REP_CHK: begin
        // One suspect is held back so that the final beat can carry last.
        if (!suspect) begin
          state_d = S_REP_RD;
        end else if (!pend_valid_q) begin
          pend_valid_d = 1'b1;
          pend_d       = ram_rdata_i;
          state_d      = S_REP_RD;
        end else if (slot_free) begin
          out_d               = '0;
          out_d.suspect_valid = 1'b1;
          out_d.suspect_ip    = pend_q.host;
          out_d.syn_total     = sat_total(pend_q.syn);
          out_d.synack_total  = sat_total(pend_q.synack);
          out_valid_d         = 1'b1;
          pend_d              = ram_rdata_i;
          state_d             = S_REP_RD;
        end
      end

      S_REP_END: begin
        if (slot_free) begin
          out_d      = '0;
          out_d.last = 1'b1;
          if (pend_valid_q) begin
            out_d.suspect_valid = 1'b1;
            out_d.suspect_ip    = pend_q.host;
            out_d.syn_total     = sat_total(pend_q.syn);
            out_d.synack_total  = sat_total(pend_q.synack);
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      used_q       <= '0;
      rd_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      used_q       <= used_d;
      rd_valid_q   <= rd_valid_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    issue_q  <= issue_d;
    rd_idx_q <= rd_idx_d;
    host_q   <= host_d;
    is_syn_q <= is_syn_d;
    status_q <= status_d;
    walk_q   <= walk_d;
    pend_q   <= pend_d;
    out_q    <= out_d;
  end

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.packet_status = out_q.packet_status;
  assign out_o.suspect_valid = out_q.suspect_valid;
  assign out_o.suspect_ip    = out_q.suspect_ip;
  assign out_o.syn_total     = out_q.syn_total;
  assign out_o.synack_total  = out_q.synack_total;
  assign out_o.last          = out_q.last;

  assign stat_o.idle = (state_q == S_IDLE);
  assign stat_o.used = used_q;

endmodule

FILE: rtl/syn_scan_detector.sv
// Channel   Dir  Beat contents
// in_i      in   kind, eth_type, ip_protocol, source_ip, dest_ip, syn_flag, ack_flag
// out_o     out  packet_status, suspect_valid, suspect_ip, syn_total, synack_total, last
// cfg       in   cfg_we_i strobe, cfg_wdata_i carries scan_ratio
//
// A counted packet is compared against each stored host in turn until a hit: the host table
// sits in one memory with a single read port, compared one entry per cycle. An ignored
// packet goes straight to its status beat; a report reads every stored host, newest first.
// A new item is accepted only once the engine is back in idle.
// Reset clears the entry count and the control state; there is no clearing pass.
// A stalled output holds the engine only when a new beat must be loaded.
module syn_scan_detector import ssd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [RatioW-1:0] cfg_wdata_i,
  ssd_in_if.sink            in_i,
  ssd_out_if.source         out_o
);

  logic [RatioW-1:0] scan_ratio_q;
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  entry_t            ram_wdata;
  logic              ram_re;
  logic [IdxW-1:0]   ram_raddr;
  entry_t            ram_rdata;
  eng_stat_t         stat;

  // Ratio register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_ratio_q <= RatioReset;
    end else if (cfg_we_i) begin
      scan_ratio_q <= cfg_wdata_i;
    end
  end

  // Host table: address and both counters in one word per entry.
  ssd_ram #(
    .Width (EntryW),
    .Depth (TableEntries)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ssd_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .scan_ratio_i (scan_ratio_q),
    .in_i         (in_i),
    .out_o        (out_o),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .stat_o       (stat)
  );

`ifndef ASSERT_OFF
  // The entry count never passes the table size.
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.used <= UsedW'(TableEntries))
    else $error("entry count beyond table size");

  // The entry count only moves together with a table write.
  a_used_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(stat.used) |-> $past(ram_we))
    else $error("entry count changed without a table write");

  // New items enter only while idle and never during a write-back.
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> (stat.idle && !ram_we))
    else $error("item accepted while busy");

  // A beat that is not the last of its item always names a suspect.
  a_mid_suspect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.last) |-> out_o.suspect_valid)
    else $error("non-final beat without suspect");
`endif

endmodule

FILE: verif/syn_scan_detector_tb.sv
module syn_scan_detector_tb import ssd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 12;
  localparam int STALL_LIMIT    = 3000;
  localparam int ENGINE_SETTLE  = 80;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS    = 18;
  localparam int IDLE_PERCENT   = 38;
  localparam int REPORT_MAX     = 10;
  localparam logic [15:0] COUNT_TOP = 16'hFFFF;

  // One input beat as the header parser would deliver it.
  typedef struct packed {
    logic        kind;
    logic [15:0] eth_type;
    logic [7:0]  ip_protocol;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic        syn_flag;
    logic        ack_flag;
  } hdr_item_t;

  // Shadow host table: predicts every result beat and checks the block against it.
  class host_count_ledger;
    logic [31:0]       host_addr[TableEntries];
    logic [15:0]       syn_cnt[TableEntries];
    logic [15:0]       synack_cnt[TableEntries];
    int                hosts_used;
    logic [RatioW-1:0] ratio;
    logic [15:0]       ratio_mask;
    out_beat_t         expected_beats[$];
    int                errors;
    int                reported;
    int                status_seen[4];
    int                reports;
    int                suspect_beats;
    int                empty_reports;

    function new();
      hosts_used = 0;
      ratio = RatioReset;
      ratio_mask = 16'(1) << RatioReset;
      errors = 0;
      reported = 0;
      reports = 0;
      suspect_beats = 0;
      empty_reports = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_ratio(logic [RatioW-1:0] r);
      ratio = r;
      ratio_mask[r] = 1'b1;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    // Update the shadow table for one accepted beat and queue its results.
    function void take_item(hdr_item_t it);
      out_beat_t   b;
      out_beat_t   found[$];
      logic [31:0] host;
      logic        is_syn;
      int          slot;
      b = '0;
      b.last = 1'b1;
      if (it.kind == KindPacket) begin
        b.packet_status = StIgnored;
        if (it.eth_type == EthIpv4 && it.ip_protocol == ProtoTcp && it.syn_flag) begin
          is_syn = !it.ack_flag;
          host = is_syn ? it.source_ip : it.dest_ip;
          slot = -1;
          for (int i = 0; i < hosts_used; i++) begin
            if (slot < 0 && host_addr[i] == host) slot = i;
          end
          if (slot >= 0) begin
            b.packet_status = StCounted;
          end else if (hosts_used < TableEntries) begin
            slot = hosts_used;
            host_addr[slot] = host;
            syn_cnt[slot] = '0;
            synack_cnt[slot] = '0;
            hosts_used++;
            b.packet_status = StNew;
          end else begin
            b.packet_status = StFull;
          end
          // Counters stick at all ones.
          if (slot >= 0) begin
            if (is_syn) begin
              if (syn_cnt[slot] != COUNT_TOP) syn_cnt[slot]++;
            end else begin
              if (synack_cnt[slot] != COUNT_TOP) synack_cnt[slot]++;
            end
          end
        end
        status_seen[b.packet_status]++;
        expected_beats.push_back(b);
      end else begin
        reports++;
        // Walk newest to oldest; a host is suspect when syn > ratio * synack.
        for (int i = hosts_used - 1; i >= 0; i--) begin
          if (int'(syn_cnt[i]) > int'(ratio) * int'(synack_cnt[i])) begin
            b = '0;
            b.suspect_valid = 1'b1;
            b.suspect_ip = host_addr[i];
            b.syn_total = syn_cnt[i];
            b.synack_total = synack_cnt[i];
            found.push_back(b);
          end
        end
        if (found.size() == 0) begin
          empty_reports++;
          b = '0;
          b.last = 1'b1;
          found.push_back(b);
        end else begin
          suspect_beats += found.size();
          found[found.size() - 1].last = 1'b1;
        end
        foreach (found[i]) expected_beats.push_back(found[i]);
      end
    endfunction

    // Compare one result beat with the oldest expectation.
    function void check_beat(out_beat_t got);
      out_beat_t want;
      logic      same;
      if (expected_beats.size() == 0) begin
        errors++;
        if (reported < REPORT_MAX) begin
          reported++;
          $display("[%0t] unexpected result beat: status %0d ip %h syn %0d synack %0d last %0d",
                   $realtime, got.packet_status, got.suspect_ip, got.syn_total,
                   got.synack_total, got.last);
        end
        return;
      end
      want = expected_beats.pop_front();
      same = (got.packet_status === want.packet_status)
          && (got.suspect_valid === want.suspect_valid)
          && (got.suspect_ip    === want.suspect_ip)
          && (got.syn_total     === want.syn_total)
          && (got.synack_total  === want.synack_total)
          && (got.last          === want.last);
      if (!same) begin
        errors++;
        if (reported < REPORT_MAX) begin
          reported++;
          $display("[%0t] result mismatch", $realtime);
          $display("  expected: status %0d valid %0d ip %h syn %0d synack %0d last %0d",
                   want.packet_status, want.suspect_valid, want.suspect_ip,
                   want.syn_total, want.synack_total, want.last);
          $display("  actual:   status %0d valid %0d ip %h syn %0d synack %0d last %0d",
                   got.packet_status, got.suspect_valid, got.suspect_ip,
                   got.syn_total, got.synack_total, got.last);
        end
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [RatioW-1:0] cfg_wdata_i;
  logic              calm;
  logic              rx_hold_req;
  int                rx_hold_left;
  int                stall_cycles = 0;
  logic [31:0]       known_hosts[$];
  host_count_ledger  ledger;

  ssd_in_if  in_if ();
  ssd_out_if out_if ();

  syn_scan_detector DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if.sink),
    .out_o       (out_if.source)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Sample both channels and the register port at the rising edge; watch for a hang.
  always @(posedge clk_i) begin
    hdr_item_t it;
    out_beat_t got;
    logic      moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_we_i) begin
        ledger.set_ratio(cfg_wdata_i);
        moved = 1'b1;
      end
      if (in_if.valid && in_if.ready) begin
        it.kind = in_if.kind;
        it.eth_type = in_if.eth_type;
        it.ip_protocol = in_if.ip_protocol;
        it.source_ip = in_if.source_ip;
        it.dest_ip = in_if.dest_ip;
        it.syn_flag = in_if.syn_flag;
        it.ack_flag = in_if.ack_flag;
        ledger.take_item(it);
        moved = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        got.packet_status = pkt_status_e'(out_if.packet_status);
        got.suspect_valid = out_if.suspect_valid;
        got.suspect_ip = out_if.suspect_ip;
        got.syn_total = out_if.syn_total;
        got.synack_total = out_if.synack_total;
        got.last = out_if.last;
        ledger.check_beat(got);
        moved = 1'b1;
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[%0t] no beat moved for %0d cycles, %0d results outstanding",
                 $realtime, STALL_LIMIT, ledger.pending());
        $display("** syn_scan_detector: FAILED **");
        $finish;
      end
    end
  end

  // Result side: random backpressure, a quiet stretch, and one long hold on request.
  initial begin
    logic rx_hold_taken;
    rx_hold_taken = 1'b0;
    rx_hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req && !rx_hold_taken) begin
        rx_hold_taken = 1'b1;
        rx_hold_left = RX_HOLD_CYCLES;
      end
      if (rx_hold_left > 0) begin
        out_if.ready = 1'b0;
        rx_hold_left--;
      end else begin
        out_if.ready = calm || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Offer one beat, with random gaps before it, and hold it until accepted.
  task automatic send_item(input hdr_item_t it);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.kind = it.kind;
    in_if.eth_type = it.eth_type;
    in_if.ip_protocol = it.ip_protocol;
    in_if.source_ip = it.source_ip;
    in_if.dest_ip = it.dest_ip;
    in_if.syn_flag = it.syn_flag;
    in_if.ack_flag = it.ack_flag;
    in_if.valid = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
  endtask

  // The ratio register is only written once the engine has drained.
  task automatic set_ratio(input logic [RatioW-1:0] r);
    wait_for_results();
    repeat (ENGINE_SETTLE) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = r;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic hdr_item_t make_pkt(logic [15:0] etype, logic [7:0] proto,
                                         logic [31:0] src, logic [31:0] dst,
                                         logic syn, logic ack);
    hdr_item_t it;
    it.kind = KindPacket;
    it.eth_type = etype;
    it.ip_protocol = proto;
    it.source_ip = src;
    it.dest_ip = dst;
    it.syn_flag = syn;
    it.ack_flag = ack;
    return it;
  endfunction

  // A report request carries random junk in its header fields.
  function automatic hdr_item_t make_report();
    hdr_item_t it;
    it = make_pkt(16'($urandom), 8'($urandom), $urandom, $urandom,
                  1'($urandom), 1'($urandom));
    it.kind = KindReport;
    return it;
  endfunction

  // Mostly well-formed SYN and SYN-ACK beats over a growing host pool,
  // with some reports and some headers broken in one field or in several.
  function automatic hdr_item_t random_item();
    hdr_item_t   it;
    int unsigned pick;
    logic [31:0] host;
    pick = $urandom_range(99);
    it = make_pkt(EthIpv4, ProtoTcp, $urandom, $urandom, 1'b1, $urandom_range(99) < 40);
    if (pick < 10) begin
      it = make_report();
    end else if (pick < 25) begin
      case ($urandom_range(3))
        0: it.eth_type = EthIpv4 ^ 16'($urandom_range(1, 65535));
        1: it.ip_protocol = ProtoTcp ^ 8'($urandom_range(1, 255));
        2: it.syn_flag = 1'b0;
        default: begin
          it.eth_type = 16'($urandom);
          it.ip_protocol = 8'($urandom);
          it.syn_flag = 1'($urandom);
        end
      endcase
    end else begin
      if (known_hosts.size() > 0 && $urandom_range(99) < 40) begin
        host = known_hosts[$urandom_range(known_hosts.size() - 1)];
      end else begin
        host = $urandom;
        known_hosts.push_back(host);
      end
      if (it.ack_flag) it.dest_ip = host;
      else it.source_ip = host;
    end
    return it;
  endfunction

  function automatic logic does_work(hdr_item_t it);
    return it.kind == KindReport
        || (it.eth_type == EthIpv4 && it.ip_protocol == ProtoTcp && it.syn_flag);
  endfunction

  // Run one random phase; only beats that do real work count toward its length.
  task automatic random_phase(input logic pause_midway);
    hdr_item_t it;
    int        useful;
    useful = 0;
    while (useful < PHASE_ITEMS) begin
      it = random_item();
      send_item(it);
      if (does_work(it)) useful++;
      if (pause_midway && useful == PHASE_ITEMS / 2) begin
        wait_for_results();
        pause_midway = 1'b0;
      end
    end
    send_item(make_report());
  endtask

  initial begin
    ledger = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    calm = 1'b0;
    rx_hold_req = 1'b0;
    in_if.valid = 1'b0;
    in_if.kind = KindPacket;
    in_if.eth_type = '0;
    in_if.ip_protocol = '0;
    in_if.source_ip = '0;
    in_if.dest_ip = '0;
    in_if.syn_flag = 1'b0;
    in_if.ack_flag = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty report, every way a header is ignored, new and known hosts.
    send_item(make_report());
    send_item(make_pkt(16'h86DD, ProtoTcp, 32'h01020304, 32'h05060708, 1'b1, 1'b0));
    send_item(make_pkt(EthIpv4, 8'd17, 32'h01020304, 32'h05060708, 1'b1, 1'b0));
    send_item(make_pkt(EthIpv4, ProtoTcp, 32'h01020304, 32'h05060708, 1'b0, 1'b1));
    send_item(make_pkt(EthIpv4, ProtoTcp, 32'h01020304, 32'h05060708, 1'b0, 1'b0));
    send_item(make_pkt(16'hFFFF, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1));
    send_item(make_pkt(16'h0000, 8'h00, 32'h00000000, 32'h00000000, 1'b1, 1'b0));
    send_item(make_pkt(EthIpv4, ProtoTcp, 32'h00000000, 32'hFFFFFFFF, 1'b1, 1'b0));
    send_item(make_pkt(EthIpv4, ProtoTcp, 32'hFFFFFFFF, 32'h00000000, 1'b1, 1'b0));
    send_item(make_pkt(EthIpv4, ProtoTcp, 32'hFFFFFFFF, 32'h12345678, 1'b1, 1'b0));
    send_item(make_pkt(EthIpv4, ProtoTcp, 32'h87654321, 32'hFFFFFFFF, 1'b1, 1'b1));
    send_item(make_pkt(EthIpv4, ProtoTcp, 32'hC0A80001, 32'h0A000001, 1'b1, 1'b1));
    known_hosts.push_back(32'h00000000);
    known_hosts.push_back(32'hFFFFFFFF);
    known_hosts.push_back(32'h0A000001);
    send_item(make_report());

    // Ratio zero flags any host with a SYN; ratio two sits right on the boundary.
    set_ratio(RatioW'(0));
    send_item(make_report());
    set_ratio(RatioW'(2));
    send_item(make_report());

    // The largest ratio leaves mostly hosts that never saw a SYN-ACK.
    set_ratio(RatioW'(15));
    send_item(make_report());

    // Random phases under different ratios and different kinds of pressure.
    set_ratio(RatioW'($urandom_range(1, 14)));
    random_phase(1'b1);
    set_ratio(RatioW'(15));
    rx_hold_req = 1'b1;
    random_phase(1'b0);
    set_ratio(RatioW'(0));
    calm = 1'b1;
    random_phase(1'b0);
    calm = 1'b0;
    set_ratio(RatioW'(3));
    random_phase(1'b0);

    wait_for_results();
    repeat (ENGINE_SETTLE) @(posedge clk_i);

    $display("Covered %0d headers (%0d ignored, %0d counted, %0d new, %0d dropped), %0d reports",
             ledger.status_seen[0] + ledger.status_seen[1] + ledger.status_seen[2]
             + ledger.status_seen[3], ledger.status_seen[0], ledger.status_seen[1],
             ledger.status_seen[2], ledger.status_seen[3], ledger.reports);
    $display("with %0d suspect beats and %0d empty; %0d ratio settings, %0d hosts stored.",
             ledger.suspect_beats, ledger.empty_reports, $countones(ledger.ratio_mask),
             ledger.hosts_used);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("** syn_scan_detector: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results never arrived", ledger.errors, ledger.pending());
      $display("** syn_scan_detector: FAILED **");
    end
    $finish;
  end

endmodule
